FILE: sv/amt_pkg.sv
`default_nettype none

package amt_pkg;

    localparam int FRAME_CLOCKS  = 21;
    localparam int ANGLE_BITS    = 9;
    localparam int COUNT_BITS    = 32;
    localparam int HALF_BITS     = 8;
    localparam int MOD_BITS      = 10;
    localparam int CLK_IDX_BITS  = 5;
    localparam int DELTA_BITS    = MOD_BITS + 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 10;

    localparam logic [HALF_BITS-1:0] HALF_RESET = HALF_BITS'(1);
    localparam logic [MOD_BITS-1:0]  MOD_RESET  = MOD_BITS'(360);

    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_PERIOD  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_TURN_MODULUS = CFG_IDX_BITS'(1);

    typedef logic [ANGLE_BITS-1:0]        angle_t;
    typedef logic signed [COUNT_BITS-1:0] count_t;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_SETUP = 5'b00010,
        PH_LOW   = 5'b00100,
        PH_HIGH  = 5'b01000,
        PH_DONE  = 5'b10000
    } phase_t;

endpackage

`default_nettype wire

FILE: sv/amt_if.sv
`default_nettype none

interface amt_tick_if;
    logic valid;
    logic ready;
    logic data_in;
    logic direction;
    logic zero_request;

    modport source (output valid, data_in, direction, zero_request, input ready);
    modport sink   (input valid, data_in, direction, zero_request, output ready);
endinterface

interface amt_result_if
    import amt_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   chip_select;
    logic   serial_clock;
    count_t position_count;
    angle_t angle;
    logic   frame_done;

    modport source (output valid, chip_select, serial_clock, position_count, angle,
                    frame_done, input ready);
    modport sink   (input valid, chip_select, serial_clock, position_count, angle,
                    frame_done, output ready);
endinterface

`default_nettype wire

FILE: sv/absolute_encoder_multiturn_tracker_top.sv
`default_nettype none
// The result is registered and offered in the cycle after its tick is accepted.
// Throughput: one tick per cycle; the result register frees itself when taken,
// so a tick is accepted whenever the result slot is empty or being emptied.
// Reset (rst_n, async, active low): sequencer idle, count zero, angle zero,
// first frame seeds the reference angle; registers to 1 and 360.

module absolute_encoder_multiturn_tracker_top
    import amt_pkg::*;
(
    input  wire                      clk,
    input  wire                      rst_n,
    amt_tick_if.sink                 tick,
    amt_result_if.source             result,
    input  wire                      cfg_we,
    input  wire [CFG_IDX_BITS-1:0]   cfg_index,
    input  wire [CFG_DATA_BITS-1:0]  cfg_data
);

    // configuration registers
    logic [HALF_BITS-1:0] half_reg;
    logic [MOD_BITS-1:0]  mod_reg;

    // sequencer and tracker state
    phase_t                  phase_reg, phase_next;
    logic [CLK_IDX_BITS-1:0] clk_idx_reg, clk_idx_next;
    logic [HALF_BITS-1:0]    div_reg, div_next;
    angle_t                  shift_reg, shift_next;
    angle_t                  prev_reg, prev_next;
    count_t                  total_reg, total_next;
    logic                    reseed_reg, reseed_next;

    // result register
    logic   out_valid_reg;
    logic   cs_reg, cs_next;
    logic   sclk_reg, sclk_next;
    logic   done_reg, done_next;

    logic                    tick_acc;
    logic [HALF_BITS-1:0]    span;
    logic                    phase_end;
    logic signed [DELTA_BITS-1:0] diff;
    logic signed [DELTA_BITS-1:0] delta;
    logic signed [DELTA_BITS-1:0] mod_s;

    // a tick enters whenever the result slot is empty or drains this cycle
    assign tick.ready = !out_valid_reg || result.ready;
    assign tick_acc   = tick.valid && tick.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HALF_RESET;
            mod_reg  <= MOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HALF_PERIOD:  half_reg <= cfg_data[HALF_BITS-1:0];
                REG_TURN_MODULUS: mod_reg  <= cfg_data[MOD_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // phase timing: a zero half period behaves as one tick
    assign span      = (half_reg == '0) ? HALF_BITS'(1) : half_reg;
    assign phase_end = ({1'b0, div_reg} + (HALF_BITS+1)'(1)) >= {1'b0, span};

    // unwrap: signed step from previous to new angle, corrected by the modulus
    // when the reading wrapped against the direction of motion
    assign mod_s = DELTA_BITS'(mod_reg);
    assign diff  = DELTA_BITS'(shift_reg) - DELTA_BITS'(prev_reg);

    always_comb
    begin
        delta = diff;
        if (tick.direction && (shift_reg < prev_reg))
            delta = diff + mod_s;
        else if (!tick.direction && (shift_reg > prev_reg))
            delta = diff - mod_s;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        clk_idx_next = clk_idx_reg;
        div_next     = div_reg;
        shift_next   = shift_reg;
        prev_next    = prev_reg;
        total_next   = total_reg;
        reseed_next  = reseed_reg;
        cs_next      = 1'b0;
        sclk_next    = 1'b0;
        done_next    = 1'b0;

        unique case (phase_reg)
            PH_SETUP:
            begin
                cs_next  = 1'b1;
                div_next = phase_end ? '0 : div_reg + HALF_BITS'(1);
                if (phase_end)
                begin
                    clk_idx_next = '0;
                    shift_next   = '0;
                    phase_next   = PH_LOW;
                end
            end
            PH_LOW:
            begin
                cs_next  = 1'b1;
                div_next = phase_end ? '0 : div_reg + HALF_BITS'(1);
                if (phase_end)
                    phase_next = PH_HIGH;
            end
            PH_HIGH:
            begin
                cs_next   = 1'b1;
                sclk_next = 1'b1;
                div_next  = phase_end ? '0 : div_reg + HALF_BITS'(1);
                if (phase_end)
                begin
                    // only the trailing bits of the frame carry the angle
                    if (({1'b0, clk_idx_reg} + (CLK_IDX_BITS+1)'(ANGLE_BITS))
                        >= (CLK_IDX_BITS+1)'(FRAME_CLOCKS))
                        shift_next = {shift_reg[ANGLE_BITS-2:0], tick.data_in};
                    if (({1'b0, clk_idx_reg} + (CLK_IDX_BITS+1)'(1))
                        >= (CLK_IDX_BITS+1)'(FRAME_CLOCKS))
                        phase_next = PH_DONE;
                    else
                    begin
                        clk_idx_next = clk_idx_reg + CLK_IDX_BITS'(1);
                        phase_next   = PH_LOW;
                    end
                end
            end
            PH_DONE:
            begin
                done_next = 1'b1;
                if (reseed_reg)
                    reseed_next = 1'b0;
                else
                    total_next = total_reg + COUNT_BITS'(delta);
                prev_next = shift_reg;
                if (tick.zero_request)
                begin
                    total_next  = '0;
                    reseed_next = 1'b1;
                end
                div_next   = '0;
                phase_next = PH_SETUP;
            end
            default:
            begin
                div_next   = '0;
                phase_next = PH_SETUP;
            end
        endcase
    end

    // state advances once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            clk_idx_reg <= '0;
            div_reg     <= '0;
            shift_reg   <= '0;
            prev_reg    <= '0;
            total_reg   <= '0;
            reseed_reg  <= 1'b1;
        end
        else if (tick_acc)
        begin
            phase_reg   <= phase_next;
            clk_idx_reg <= clk_idx_next;
            div_reg     <= div_next;
            shift_reg   <= shift_next;
            prev_reg    <= prev_next;
            total_reg   <= total_next;
            reseed_reg  <= reseed_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (tick_acc)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            cs_reg   <= cs_next;
            sclk_reg <= sclk_next;
            done_reg <= done_next;
        end
    end

    // count and angle are read straight from the tracker state, which
    // only moves together with the result register
    assign result.valid          = out_valid_reg;
    assign result.chip_select    = cs_reg;
    assign result.serial_clock   = sclk_reg;
    assign result.frame_done     = done_reg;
    assign result.position_count = total_reg;
    assign result.angle          = prev_reg;

    // checks
    a_done_lines_low: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.frame_done) |-> (!result.chip_select && !result.serial_clock))
        else $error("frame end with encoder lines active");

    a_sclk_needs_cs: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.serial_clock) |-> result.chip_select)
        else $error("serial clock outside chip select");

    a_done_follows_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_acc && (phase_reg == PH_DONE)) |=> (result.valid && result.frame_done))
        else $error("closing tick gave no frame end");

    a_reseed_clears_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(reseed_reg) |-> $past(tick_acc && (phase_reg == PH_DONE)))
        else $error("reseed cleared outside frame end");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none

module testbench
    import amt_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = CFG_IDX_BITS'(2);

    // Ticks per frame at a half period of one; used to size the data patterns.
    localparam int FRAME_TICKS = 2 * FRAME_CLOCKS + 2;

    typedef struct packed {
        logic data_in;
        logic direction;
        logic zero_request;
    } tick_t;

    typedef struct packed {
        logic   chip_select;
        logic   serial_clock;
        count_t position_count;
        angle_t angle;
        logic   frame_done;
    } tracker_out_t;

    // Serial data patterns for a run of ticks.
    typedef enum {
        PAT_RANDOM,
        PAT_ZEROS,
        PAT_ONES,
        PAT_MIXED
    } pattern_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    amt_tick_if   tick_ch ();
    amt_result_if result_ch ();

    absolute_encoder_multiturn_tracker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the tracker: configuration and sequencer state
    // ------------------------------------------------------------------
    logic [HALF_BITS-1:0]    half_cfg;
    logic [MOD_BITS-1:0]     mod_cfg;
    phase_t                  seq_phase;
    logic [CLK_IDX_BITS-1:0] pulse_idx;
    logic [HALF_BITS-1:0]    span_div;
    angle_t                  shift_reg;
    angle_t                  last_angle;
    logic [COUNT_BITS-1:0]   turn_total;
    bit                      reseed;

    // Stimulus and expectation stores
    tick_t        pending_ticks[$];
    tracker_out_t expected_outputs[$];
    tick_t        offered;

    // Handshake bookkeeping shared between the clocked processes
    bit tick_taken;
    int send_gap;
    int ready_gap;
    bit no_idle;
    bit hold_request;
    int hold_left;
    int fail_count;
    int result_count;

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Advances the divider; true on the last tick of a phase. A half period
    // of zero behaves as one.
    function automatic bit span_elapsed();
        int span;
        span = (half_cfg == '0) ? 1 : int'(half_cfg);
        if (int'(span_div) + 1 >= span) begin
            span_div = '0;
            return 1'b1;
        end
        span_div = span_div + HALF_BITS'(1);
        return 1'b0;
    endfunction

    // Frame end: unwrap the new reading against the previous one.
    task automatic close_frame(input logic fwd, input logic zero);
        logic [COUNT_BITS-1:0] c;
        logic [COUNT_BITS-1:0] p;
        logic [COUNT_BITS-1:0] m;
        logic [COUNT_BITS-1:0] acc;
        c   = COUNT_BITS'(shift_reg);
        p   = COUNT_BITS'(last_angle);
        m   = COUNT_BITS'(mod_cfg);
        acc = turn_total;
        if (reseed) begin
            reseed = 1'b0;
        end
        else if (fwd) begin
            if (c > p)
                acc = acc + (c - p);
            else if (c < p)
                acc = acc + m - p + c;
        end
        else begin
            if (c < p)
                acc = acc - (p - c);
            else if (c > p)
                acc = acc - (p + m - c);
        end
        last_angle = shift_reg;
        if (zero) begin
            acc    = '0;
            reseed = 1'b1;
        end
        turn_total = acc;
    endtask

    // One tick through the shadow tracker.
    task automatic step_tracker(input tick_t t, output tracker_out_t r);
        r = '0;
        case (seq_phase)
            PH_SETUP:
            begin
                r.chip_select = 1'b1;
                if (span_elapsed()) begin
                    pulse_idx = '0;
                    shift_reg = '0;
                    seq_phase = PH_LOW;
                end
            end
            PH_LOW:
            begin
                r.chip_select = 1'b1;
                if (span_elapsed())
                    seq_phase = PH_HIGH;
            end
            PH_HIGH:
            begin
                r.chip_select  = 1'b1;
                r.serial_clock = 1'b1;
                if (span_elapsed()) begin
                    // only the trailing pulses carry angle bits
                    if (int'(pulse_idx) + ANGLE_BITS >= FRAME_CLOCKS)
                        shift_reg = {shift_reg[ANGLE_BITS-2:0], t.data_in};
                    if (int'(pulse_idx) + 1 >= FRAME_CLOCKS) begin
                        seq_phase = PH_DONE;
                    end
                    else begin
                        pulse_idx = pulse_idx + CLK_IDX_BITS'(1);
                        seq_phase = PH_LOW;
                    end
                end
            end
            PH_DONE:
            begin
                r.frame_done = 1'b1;
                close_frame(t.direction, t.zero_request);
                span_div  = '0;
                seq_phase = PH_SETUP;
            end
            default:
            begin
                span_div  = '0;
                seq_phase = PH_SETUP;
            end
        endcase
        r.position_count = count_t'(turn_total);
        r.angle          = last_angle;
    endtask

    // Mostly back-to-back, sometimes a short gap, now and then a long gap.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // ------------------------------------------------------------------
    // Tick driver: changes on the falling edge, holds until taken
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            tick_ch.valid <= 1'b0;
        end
        else if (!tick_ch.valid || tick_taken) begin
            tick_taken = 1'b0;
            if (no_idle)
                send_gap = 0;
            if (send_gap > 0) begin
                send_gap--;
                tick_ch.valid <= 1'b0;
            end
            else if (pending_ticks.size() > 0) begin
                offered = pending_ticks.pop_front();
                tick_ch.valid        <= 1'b1;
                tick_ch.data_in      <= offered.data_in;
                tick_ch.direction    <= offered.direction;
                tick_ch.zero_request <= offered.zero_request;
                send_gap = pick_gap();
            end
            else begin
                tick_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result ready: random stalls, or held low during a back-pressure spell
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
        end
        else if (hold_left > 0) begin
            result_ch.ready <= 1'b0;
        end
        else if (no_idle) begin
            result_ch.ready <= 1'b1;
        end
        else if (ready_gap > 0) begin
            ready_gap--;
            result_ch.ready <= 1'b0;
        end
        else begin
            result_ch.ready <= 1'b1;
            ready_gap = pick_gap();
        end
    end

    // Back-pressure spell, counted here in cycles so the sender keeps
    // offering ticks while the result side is shut.
    always @(posedge clk) begin
        if (hold_request) begin
            hold_left    = 300;
            hold_request = 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left--;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on tick acceptance first, then check any result,
    // so that the order is right whatever the latency.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        tracker_out_t want;
        tracker_out_t got;
        if (rst_n) begin
            if (tick_ch.valid && tick_ch.ready) begin
                step_tracker(offered, want);
                expected_outputs.push_back(want);
                tick_taken = 1'b1;
            end
            if (result_ch.valid && result_ch.ready) begin
                got.chip_select    = result_ch.chip_select;
                got.serial_clock   = result_ch.serial_clock;
                got.position_count = result_ch.position_count;
                got.angle          = result_ch.angle;
                got.frame_done     = result_ch.frame_done;
                if (expected_outputs.size() == 0) begin
                    note_failure($sformatf("result %0d arrived with nothing outstanding",
                                           result_count));
                end
                else begin
                    want = expected_outputs.pop_front();
                    if (got.chip_select !== want.chip_select
                        || got.serial_clock !== want.serial_clock
                        || got.position_count !== want.position_count
                        || got.angle !== want.angle
                        || got.frame_done !== want.frame_done)
                        note_failure($sformatf(
                            {"result %0d: exp cs=%0b sclk=%0b count=%0d angle=%0d done=%0b",
                             " got cs=%0b sclk=%0b count=%0d angle=%0d done=%0b"},
                            result_count, want.chip_select, want.serial_clock,
                            want.position_count, want.angle, want.frame_done,
                            got.chip_select, got.serial_clock, got.position_count,
                            got.angle, got.frame_done));
                end
                result_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queues n ticks. Direction is held and, if wander is set, flips now and
    // then with occasional single-tick noise. Zero requests at zero_pct %.
    task automatic queue_ticks(input int n, input pattern_t pat, input logic fwd,
                               input bit wander, input int zero_pct);
        tick_t t;
        logic  dir;
        logic  level;
        int    chunk;
        bit    steady;
        dir    = fwd;
        level  = 1'b0;
        chunk  = 0;
        steady = 1'b0;
        for (int i = 0; i < n; i++) begin
            // mixed: roughly frame-long runs of random bits or a fixed level,
            // the latter gives repeated identical readings
            if (pat == PAT_MIXED) begin
                if (chunk == 0) begin
                    chunk  = FRAME_TICKS;
                    steady = ($urandom_range(0, 4) >= 3);
                    level  = 1'($urandom_range(0, 1));
                end
                chunk--;
            end
            case (pat)
                PAT_ZEROS: t.data_in = 1'b0;
                PAT_ONES:  t.data_in = 1'b1;
                default:   t.data_in = steady ? level : 1'($urandom_range(0, 1));
            endcase
            if (wander && $urandom_range(0, 29) == 0)
                dir = ~dir;
            t.direction    = (wander && $urandom_range(0, 19) == 0) ?
                             1'($urandom_range(0, 1)) : dir;
            t.zero_request = ($urandom_range(0, 99) < zero_pct);
            pending_ticks.push_back(t);
        end
    endtask

    // Register write on the falling edge; the shadow copy follows at once,
    // which is safe since nothing is in flight.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
        logic [CFG_DATA_BITS-1:0] word;
        word = CFG_DATA_BITS'(val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        case (idx)
            REG_HALF_PERIOD:  half_cfg = word[HALF_BITS-1:0];
            REG_TURN_MODULUS: mod_cfg  = word[MOD_BITS-1:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sender pauses until every predicted result has been seen, then waits on
    // past the result register.
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || tick_ch.valid || expected_outputs.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        tick_ch.valid          = 1'b0;
        tick_ch.data_in        = 1'b0;
        tick_ch.direction      = 1'b0;
        tick_ch.zero_request   = 1'b0;
        result_ch.ready        = 1'b0;
        tick_taken             = 1'b0;
        send_gap               = 0;
        ready_gap              = 0;
        no_idle                = 1'b0;
        hold_request           = 1'b0;
        hold_left              = 0;
        fail_count             = 0;
        result_count           = 0;
        offered                = '0;

        half_cfg   = HALF_RESET;
        mod_cfg    = MOD_RESET;
        seq_phase  = PH_IDLE;
        pulse_idx  = '0;
        span_div   = '0;
        shift_reg  = '0;
        last_angle = '0;
        turn_total = '0;
        reseed     = 1'b1;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames at reset settings. The first frame only seeds
        // (reading 511), the second repeats it so nothing moves.
        queue_ticks(FRAME_TICKS + 1 + FRAME_TICKS, PAT_ONES, 1'b1, 1'b0, 0);
        // forward onto a smaller reading: wrap correction upwards
        queue_ticks(FRAME_TICKS, PAT_ZEROS, 1'b1, 1'b0, 0);
        // backward onto a larger reading: wrap correction downwards
        queue_ticks(FRAME_TICKS, PAT_ONES, 1'b0, 1'b0, 0);
        // zero request held through a whole frame: count clears, reseed due
        queue_ticks(FRAME_TICKS, PAT_ONES, 1'b1, 1'b0, 100);
        // this frame must only seed again
        queue_ticks(FRAME_TICKS, PAT_ZEROS, 1'b0, 1'b0, 0);
        wait_drained();

        // Zero half period (acts as one) with the smallest nonzero modulus
        write_reg(REG_HALF_PERIOD, 0);
        write_reg(REG_TURN_MODULUS, 1);
        queue_ticks(35, PAT_MIXED, 1'b1, 1'b1, 10);
        wait_drained();

        // Largest modulus in range; result side shut for a long spell while
        // the sender keeps going, so the block fills and stalls its input
        write_reg(REG_HALF_PERIOD, 1);
        write_reg(REG_TURN_MODULUS, 512);
        no_idle      = 1'b1;
        hold_request = 1'b1;
        queue_ticks(35, PAT_MIXED, 1'b0, 1'b1, 10);
        wait_drained();
        no_idle = 1'b0;

        // Write to an index with no register, then a zero modulus
        write_reg(REG_SPARE, $urandom_range(0, 1023));
        write_reg(REG_HALF_PERIOD, 2);
        write_reg(REG_TURN_MODULUS, 0);
        queue_ticks(20, PAT_MIXED, 1'b1, 1'b1, 10);
        wait_drained();

        // All-ones modulus, above the nominal range
        write_reg(REG_HALF_PERIOD, 1);
        write_reg(REG_TURN_MODULUS, 1023);
        queue_ticks(25, PAT_MIXED, 1'b0, 1'b1, 10);
        wait_drained();

        // Slowest clock: only part of a low phase
        write_reg(REG_HALF_PERIOD, 255);
        write_reg(REG_TURN_MODULUS, 360);
        queue_ticks(10, PAT_RANDOM, 1'b1, 1'b1, 10);
        wait_drained();

        write_reg(REG_HALF_PERIOD, 3);
        write_reg(REG_TURN_MODULUS, $urandom_range(1, 512));
        queue_ticks(15, PAT_MIXED, 1'b1, 1'b1, 10);
        wait_drained();

        // Back to reset settings; the mid-frame change above restarts nothing
        write_reg(REG_HALF_PERIOD, 1);
        write_reg(REG_TURN_MODULUS, 360);
        queue_ticks(15, PAT_MIXED, 1'b0, 1'b1, 10);
        wait_drained();

        repeat (4) @(negedge clk);
        if (fail_count == 0 && expected_outputs.size() == 0)
            $display("absolute_encoder_multiturn_tracker_top verification clean");
        else
            $display("absolute_encoder_multiturn_tracker_top verification failed");
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #5_000_000;
        $display("absolute_encoder_multiturn_tracker_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire
